@@ src/stc_pkg.sv @@
// shared types and constants for the smbios structure type counter
package stc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int CFG_ADDR_WIDTH = 3;
	localparam logic REG_WANTED_TYPE = 1'b0;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic                   valid;
		logic [COUNT_WIDTH-1:0] count;
		logic                   short_table;
	} result_t;

endpackage

@@ src/smbios_type_counter.sv @@
// top level: input register, structure walk, result register and config port
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------
//  bytes    | data_valid    | data_stall    | data_byte, last_byte
//  result   | result_valid  | result_stall  | type_count, short_table
//  config   | psel/penable  | (pready = 1)  | paddr, pwdata, prdata
//
// one byte a cycle while data_stall is low; the walk takes a byte from the
// input register and the result register is loaded at that same edge, so a
// count passes through the input register and the result register. reset
// clears the walk and wanted_type to zero. a last byte waits in the input
// register while an earlier result sits stalled; other bytes leave the input
// register regardless of result_stall.
module smbios_type_counter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               data_valid,
	output logic                               data_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               last_byte,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [stc_pkg::COUNT_WIDTH-1:0]    type_count,
	output logic                               short_table,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import stc_pkg::*;

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;
	logic                   out_blocked;
	logic                   consume;
	logic                   s1_free;
	logic                   accept;
	logic [7:0]             wanted_type;
	item_t                  item;
	result_t                res;
	logic                   result_valid_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   short_q;

	stc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.wanted_type (wanted_type)
	);

	// a last byte only moves on once the result register can take it
	assign out_blocked = result_valid_q && result_stall;
	assign consume     = valid_s1 && !(last_s1 && out_blocked);
	assign s1_free     = !valid_s1 || consume;
	assign data_stall  = !s1_free;
	assign accept      = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign item.valid = consume;
	assign item.data  = data_s1;
	assign item.last  = last_s1;

	stc_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.wanted_type (wanted_type),
		.item        (item),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res.valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			count_q <= res.count;
			short_q <= res.short_table;
		end
	end

	assign result_valid = result_valid_q;
	assign type_count   = count_q;
	assign short_table  = short_q;

endmodule

@@ src/stc_cfg.sv @@
// apb register block holding the wanted structure type
module stc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [7:0]                         wanted_type
);
	import stc_pkg::*;

	logic [7:0] wanted_q;
	logic       reg_index;

	assign reg_index   = paddr[CFG_ADDR_WIDTH-1];
	assign pready      = 1'b1;
	assign wanted_type = wanted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && reg_index == REG_WANTED_TYPE) begin
			wanted_q <= pwdata[7:0];
		end
	end

	always_comb begin
		case (reg_index)
			REG_WANTED_TYPE: prdata = {24'd0, wanted_q};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

@@ src/stc_walk.sv @@
// per-byte structure walk state and end-of-table result logic
module stc_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       wanted_type,
	input  stc_pkg::item_t   item,
	output stc_pkg::result_t result
);
	import stc_pkg::*;

	localparam logic [1:0] PH_TYPE      = 2'd0;
	localparam logic [1:0] PH_LENGTH    = 2'd1;
	localparam logic [1:0] PH_FORMATTED = 2'd2;
	localparam logic [1:0] PH_STRINGS   = 2'd3;
	localparam logic [2:0] SEEN_MAX     = 3'd5;
	localparam logic [2:0] SEEN_MIN     = 3'd4;

	logic [1:0]             phase_q, phase_d;
	logic [7:0]             offset_q, offset_d;
	logic [7:0]             flen_q, flen_d;
	logic                   zrun_q, zrun_d;
	logic                   first_q, first_d;
	logic [COUNT_WIDTH-1:0] later_q, later_d;
	logic [2:0]             seen_q, seen_d;
	logic [7:0]             ftype_q, ftype_d;
	logic [COUNT_WIDTH-1:0] total;
	logic [7:0]             b;

	assign b = item.data;

	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		flen_d   = flen_q;
		zrun_d   = zrun_q;
		first_d  = first_q;
		later_d  = later_q;
		ftype_d  = ftype_q;
		seen_d   = (seen_q < SEEN_MAX) ? seen_q + 3'd1 : seen_q;

		case (phase_q)
			PH_TYPE: begin
				ftype_d = b;
				if (seen_q == 3'd0) begin
					first_d = (b == wanted_type);
				end else if (b == wanted_type && later_q != COUNT_MAX) begin
					later_d = later_q + COUNT_WIDTH'(1);
				end
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				flen_d = b;
				zrun_d = 1'b0;
				if (b == 8'd0) begin
					// zero length: type 0 restarts the scan at the type byte, any other type goes on to the strings
					if (ftype_q == 8'd0) begin
						phase_d = PH_TYPE;
					end else begin
						zrun_d  = 1'b1;
						phase_d = PH_STRINGS;
					end
				end else if (b <= 8'd2) begin
					phase_d = PH_STRINGS;
				end else begin
					offset_d = 8'd2;
					phase_d  = PH_FORMATTED;
				end
			end
			PH_FORMATTED: begin
				if ({1'b0, offset_q} + 9'd1 >= {1'b0, flen_q}) begin
					zrun_d  = 1'b0;
					phase_d = PH_STRINGS;
				end else begin
					offset_d = offset_q + 8'd1;
				end
			end
			default: begin
				if (b == 8'd0) begin
					if (zrun_q) begin
						zrun_d  = 1'b0;
						phase_d = PH_TYPE;
					end else begin
						zrun_d = 1'b1;
					end
				end else begin
					zrun_d = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		total = '0;
		if (seen_d > SEEN_MIN) begin
			total = (later_d == COUNT_MAX) ? later_d
				: later_d + COUNT_WIDTH'(first_d);
		end
		result.valid       = item.valid && item.last;
		result.count       = total;
		result.short_table = (seen_d < SEEN_MIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			offset_q <= 8'd0;
			flen_q   <= 8'd0;
			zrun_q   <= 1'b0;
			first_q  <= 1'b0;
			later_q  <= '0;
			seen_q   <= 3'd0;
			ftype_q  <= 8'd0;
		end else if (item.valid) begin
			if (item.last) begin
				phase_q  <= PH_TYPE;
				offset_q <= 8'd0;
				flen_q   <= 8'd0;
				zrun_q   <= 1'b0;
				first_q  <= 1'b0;
				later_q  <= '0;
				seen_q   <= 3'd0;
				ftype_q  <= 8'd0;
			end else begin
				phase_q  <= phase_d;
				offset_q <= offset_d;
				flen_q   <= flen_d;
				zrun_q   <= zrun_d;
				first_q  <= first_d;
				later_q  <= later_d;
				seen_q   <= seen_d;
				ftype_q  <= ftype_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.last |=> phase_q == PH_TYPE && seen_q == 3'd0)
		else $error("walk state not cleared after table end");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_MAX)
		else $error("byte counter ran past its saturation point");
	a_formatted_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FORMATTED |-> flen_q > 8'd2 && offset_q < flen_q)
		else $error("formatted section walk out of range");
	a_short_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.short_table |-> result.count == '0)
		else $error("short table reported a nonzero count");
`endif

endmodule
